/* rtl/ros_pkg.sv */
// ---------------------------------------------------------------------------
// ros_pkg: shared definitions for the retransmission output scaler
// Field widths, register indexes, calibration codes, reset values and the
// drive clamp used by the core.
// ---------------------------------------------------------------------------
package ros_pkg;

  // field widths
  localparam int PV_W       = 16;
  localparam int DRV_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MAG_W      = 12;   // |output_high - low drive| fits here
  localparam int SPAN_W     = 17;   // input_high - input_low
  localparam int PROD_W     = PV_W + MAG_W;
  localparam int LO_W       = 13;   // extrapolated low drive, signed
  localparam int SUM_W      = 14;   // interpolated result, signed

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_BASED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_MODE  = 3'd5;

  // calibration modes
  localparam logic [1:0] CAL_NORMAL     = 2'd0;
  localparam logic [1:0] CAL_FORCE_LOW  = 2'd1;
  localparam logic [1:0] CAL_FORCE_HIGH = 2'd2;
  localparam logic [1:0] CAL_HOLD       = 2'd3;

  // register reset values
  localparam logic [PV_W-1:0]  RST_INPUT_LOW   = 16'd0;
  localparam logic [PV_W-1:0]  RST_INPUT_HIGH  = 16'd1000;
  localparam logic [DRV_W-1:0] RST_OUTPUT_LOW  = 11'd400;
  localparam logic [DRV_W-1:0] RST_OUTPUT_HIGH = 11'd2000;

  localparam logic [DRV_W-1:0] DRIVE_MIN = 11'd1;
  localparam logic [DRV_W-1:0] DRIVE_MAX = 11'd2047;

  // status of the serial multiply/divide unit
  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

  // floor at one, saturate at full scale
  function automatic logic [DRV_W-1:0] clamp_drive(input logic signed [SUM_W-1:0] r);
    logic [DRV_W-1:0] res;
    if (r < $signed(SUM_W'(1))) begin
      res = DRIVE_MIN;
    end else if (r > $signed({{(SUM_W-DRV_W){1'b0}}, DRIVE_MAX})) begin
      res = DRIVE_MAX;
    end else begin
      res = r[DRV_W-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/ros_if.sv */
// ---------------------------------------------------------------------------
// ros_if: channel interfaces of the retransmission output scaler
// Sample, result and configuration write channels with valid/ready.
// ---------------------------------------------------------------------------
interface ros_sample_if;
  logic                            valid;
  logic                            ready;
  logic signed [ros_pkg::PV_W-1:0] process_value;
  logic                            editing_hold;

  modport source (output valid, process_value, editing_hold, input ready);
  modport sink   (input valid, process_value, editing_hold, output ready);
endinterface

interface ros_result_if;
  logic                       valid;
  logic                       ready;
  logic [ros_pkg::DRV_W-1:0]  drive_value;
  logic [7:0]                 pwm_coarse;
  logic [2:0]                 pwm_fine;

  modport source (output valid, drive_value, pwm_coarse, pwm_fine, input ready);
  modport sink   (input valid, drive_value, pwm_coarse, pwm_fine, output ready);
endinterface

interface ros_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ros_pkg::CFG_IDX_W-1:0]   index;
  logic [ros_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/ros_muldiv.sv */
// ---------------------------------------------------------------------------
// ros_muldiv: serial multiply then divide
// Forms a*b one multiplier bit per cycle, then divides by span one quotient
// bit per cycle with a restoring divider. The quotient is known to fit in
// MAG_W bits because a < span.
// ---------------------------------------------------------------------------
module ros_muldiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ros_pkg::PV_W-1:0]    mul_a,
  input  logic [ros_pkg::MAG_W-1:0]   mul_b,
  input  logic [ros_pkg::SPAN_W-1:0]  span,
  output logic [ros_pkg::MAG_W-1:0]   quotient,
  output ros_pkg::md_stat_t           stat
);
  import ros_pkg::*;

  localparam logic [1:0] MD_IDLE = 2'd0;
  localparam logic [1:0] MD_MUL  = 2'd1;
  localparam logic [1:0] MD_DIV  = 2'd2;
  localparam int CNT_W = $clog2(MAG_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);

  logic [1:0]        phase;
  logic [CNT_W-1:0]  count;
  logic              done;
  logic [PV_W-1:0]   a_r;
  logic [MAG_W-1:0]  b_sh;
  logic [SPAN_W-1:0] span_r;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] acc_step;
  logic [SPAN_W-1:0] rem;
  logic [MAG_W-1:0]  low_sh;

  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   trial_diff;

  // one shift-add step of the product
  assign acc_step = {acc[PROD_W-2:0], 1'b0} + (b_sh[MAG_W-1] ? {{MAG_W{1'b0}}, a_r} : '0);

  // one restoring step: shift in the next dividend bit, try the subtract
  assign trial      = {rem, low_sh[MAG_W-1]};
  assign trial_diff = trial - {1'b0, span_r};

  // sequence the multiply and divide passes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MD_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        MD_IDLE: begin
          if (start) begin
            phase <= MD_MUL;
            count <= '0;
          end
        end
        MD_MUL: begin
          if (count == CNT_LAST) begin
            phase <= MD_DIV;
            count <= '0;
          end else begin
            count <= count + 1'b1;
          end
        end
        MD_DIV: begin
          if (count == CNT_LAST) begin
            phase <= MD_IDLE;
            done  <= 1'b1;
          end else begin
            count <= count + 1'b1;
          end
        end
        default: begin
          phase <= MD_IDLE;
        end
      endcase
    end
  end

  // datapath: shift-add product, then quotient bits shift into low_sh
  always_ff @(posedge clk) begin
    if (phase == MD_IDLE && start) begin
      a_r    <= mul_a;
      b_sh   <= mul_b;
      span_r <= span;
      acc    <= '0;
    end else if (phase == MD_MUL) begin
      acc  <= acc_step;
      b_sh <= {b_sh[MAG_W-2:0], 1'b0};
    end
    if (phase == MD_MUL && count == CNT_LAST) begin
      // high part is below span, so the quotient needs only MAG_W bits
      rem    <= {1'b0, acc_step[PROD_W-1:MAG_W]};
      low_sh <= acc_step[MAG_W-1:0];
    end else if (phase == MD_DIV) begin
      if (!trial_diff[SPAN_W]) begin
        rem <= trial_diff[SPAN_W-1:0];
      end else begin
        rem <= trial[SPAN_W-1:0];
      end
      low_sh <= {low_sh[MAG_W-2:0], ~trial_diff[SPAN_W]};
    end
  end

  assign quotient  = low_sh;
  assign stat.busy = (phase != MD_IDLE);
  assign stat.done = done;

`ifndef ASSERT_OFF
  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    (phase == MD_DIV) |-> (rem < span_r))
    else $error("divider remainder not below span");

  a_done_after_div: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(phase) == MD_DIV && phase == MD_IDLE))
    else $error("done without a finished divide pass");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    (phase == MD_MUL && count != CNT_LAST) |=> (phase == MD_MUL))
    else $error("multiply pass cut short");
`endif

endmodule

/* rtl/retransmission_output_scaler_core.sv */
// ---------------------------------------------------------------------------
// retransmission_output_scaler_core: one retransmission output channel
// Scales a process value into an eleven bit drive code with PWM split.
// ---------------------------------------------------------------------------
// Usage:
//   cfg    - register writes (index, data); ready whenever out of reset,
//            write only while the block is idle. Indexes beyond calib_mode
//            are ignored.
//   sample - process_value and editing_hold; one beat is taken at a time,
//            ready is high only while no sample is in progress.
//   result - drive_value, pwm_coarse, pwm_fine; one beat per sample.
// Sequence: forced, held and out-of-range samples are loaded into res on
//   acceptance and move to the output register from the S_FIN state.
//   Interpolated samples first run through the serial multiplier, one
//   multiplier bit at a time, and the restoring divider, one quotient bit
//   at a time, before res is loaded. A new sample is taken only once the
//   previous one has left S_FIN; the multiply/divide unit sets the pace.
// Reset: registers return to 0/1000/400/2000/0/0 and the held drive to 0;
//   both input channels hold ready low while reset is asserted.
// Stall: a result waits in the output register; a finished sample waits
//   in place until the register frees, and no new sample is taken.
// ---------------------------------------------------------------------------
module retransmission_output_scaler_core (
  input  logic  clk,
  input  logic  rst,
  ros_cfg_if.sink      cfg,
  ros_sample_if.sink   sample,
  ros_result_if.source result
);
  import ros_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MATH = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  // configuration registers
  logic signed [PV_W-1:0] input_low;
  logic signed [PV_W-1:0] input_high;
  logic [DRV_W-1:0]       output_low;
  logic [DRV_W-1:0]       output_high;
  logic                   zero_based_mode;
  logic [1:0]             calib_mode;

  // control and result state
  logic [1:0]             state;
  logic [DRV_W-1:0]       res;
  logic [DRV_W-1:0]       held_output;
  logic                   out_valid;
  logic signed [LO_W-1:0] lo_r;
  logic                   m_neg_r;

  logic                   accept;
  logic [SUM_W-1:0]       five_ol;
  logic signed [LO_W+1:0] x;
  logic signed [LO_W+1:0] x_adj;
  logic signed [LO_W+1:0] x_quarter;
  logic signed [LO_W-1:0] lo_drive;
  logic signed [SUM_W-1:0] m;
  logic [SUM_W-1:0]       m_mag;
  logic [SPAN_W-1:0]      diff;
  logic [SPAN_W-1:0]      span;
  logic                   at_low;
  logic                   at_high;
  logic [MAG_W-1:0]       quotient;
  logic signed [SUM_W-1:0] q_signed;
  logic signed [SUM_W-1:0] interp;
  md_stat_t               md_stat;

  assign accept     = sample.valid && sample.ready;
  assign sample.ready = (state == S_IDLE) && !rst;
  assign cfg.ready  = !rst;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      input_low       <= RST_INPUT_LOW;
      input_high      <= RST_INPUT_HIGH;
      output_low      <= RST_OUTPUT_LOW;
      output_high     <= RST_OUTPUT_HIGH;
      zero_based_mode <= 1'b0;
      calib_mode      <= CAL_NORMAL;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_INPUT_LOW:   input_low       <= cfg.data;
        REG_INPUT_HIGH:  input_high      <= cfg.data;
        REG_OUTPUT_LOW:  output_low      <= cfg.data[DRV_W-1:0];
        REG_OUTPUT_HIGH: output_high     <= cfg.data[DRV_W-1:0];
        REG_ZERO_BASED:  zero_based_mode <= cfg.data[0];
        REG_CALIB_MODE:  calib_mode      <= cfg.data[1:0];
        default: begin
        end
      endcase
    end
  end

  // low drive: output_low, or (5*low - high)/4 truncated toward zero
  assign five_ol   = {1'b0, output_low, 2'b00} + {3'b000, output_low};
  assign x         = $signed({1'b0, five_ol}) - $signed({4'b0000, output_high});
  assign x_adj     = x + (x[LO_W+1] ? (LO_W+2)'(3) : '0);
  assign x_quarter = x_adj >>> 2;
  assign lo_drive  = zero_based_mode ? $signed({2'b00, output_low})
                                     : x_quarter[LO_W-1:0];

  // slope numerator, magnitude and sign
  assign m     = $signed({3'b000, output_high}) - $signed({lo_drive[LO_W-1], lo_drive});
  assign m_mag = m[SUM_W-1] ? (-m) : m;

  // limit tests and interpolation operands
  assign at_low  = (sample.process_value <= input_low);
  assign at_high = (sample.process_value >= input_high);
  assign diff = {sample.process_value[PV_W-1], sample.process_value}
              - {input_low[PV_W-1], input_low};
  assign span = {input_high[PV_W-1], input_high} - {input_low[PV_W-1], input_low};

  ros_muldiv u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && calib_mode == CAL_NORMAL && !sample.editing_hold &&
               !at_low && !at_high),
    .mul_a    (diff[PV_W-1:0]),
    .mul_b    (m_mag[MAG_W-1:0]),
    .span     (span),
    .quotient (quotient),
    .stat     (md_stat)
  );

  // apply sign, add back the low drive
  assign q_signed = m_neg_r ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
  assign interp   = q_signed + $signed({lo_r[LO_W-1], lo_r});

  // sample sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (calib_mode == CAL_NORMAL && !sample.editing_hold &&
                      !at_low && !at_high) ? S_MATH : S_FIN;
          end
        end
        S_MATH: begin
          if (md_stat.done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // pick the drive for the sample
  always_ff @(posedge clk) begin
    if (accept) begin
      lo_r    <= lo_drive;
      m_neg_r <= m[SUM_W-1];
      unique case (calib_mode)
        CAL_FORCE_LOW:  res <= output_low;
        CAL_FORCE_HIGH: res <= output_high;
        CAL_HOLD:       res <= held_output;
        default: begin
          priority if (sample.editing_hold) begin
            res <= held_output;
          end else if (at_low) begin
            res <= clamp_drive($signed({lo_drive[LO_W-1], lo_drive}));
          end else if (at_high) begin
            res <= clamp_drive($signed({3'b000, output_high}));
          end else begin
            res <= res;
          end
        end
      endcase
    end else if (state == S_MATH && md_stat.done) begin
      res <= clamp_drive(interp);
    end
  end

  // output register, which also holds the previous drive
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      held_output <= '0;
    end else begin
      if (state == S_FIN && (!out_valid || result.ready)) begin
        out_valid   <= 1'b1;
        held_output <= res;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.drive_value = held_output;
  assign result.pwm_coarse  = held_output[DRV_W-1:3];
  assign result.pwm_fine    = held_output[2:0];

`ifndef ASSERT_OFF
  a_idle_unit: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !md_stat.busy)
    else $error("divider busy while no sample in progress");

  a_done_in_math: assert property (@(posedge clk) disable iff (rst)
    md_stat.done |-> (state == S_MATH))
    else $error("divider result with no sample waiting");

  a_force_low: assert property (@(posedge clk) disable iff (rst)
    (accept && calib_mode == CAL_FORCE_LOW) |=> (state == S_FIN && res == $past(output_low)))
    else $error("forced low drive not loaded");

  a_load_frees: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!out_valid || result.ready)) |=> (out_valid && held_output == $past(res)))
    else $error("finished drive not moved to output register");
`endif

endmodule
